// ===== design/frt_pkg.sv =====
// Shared types and constants for the fragment reassembly tracker.
package frt_pkg;

  localparam int SLOTS_DEF      = 8;
  localparam int MAX_FRAGS_DEF  = 16;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int MSG_BYTES_DEF  = 64;
  localparam int MAX_BLOCKS_DEF = 16;

  // position and block count widths cover the whole parameter range
  localparam int POS_W = 23;
  localparam int NB_W  = 7;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_RELEASED = 3'd5,
    ST_NOTFOUND = 3'd6,
    ST_RANGE    = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_RETX   = 2'd1,
    KIND_OTHER  = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_t;

  typedef enum logic {
    REQ_FRAG    = 1'b0,
    REQ_RELEASE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    req_t              req_type;
    kind_t             kind;
    logic [31:0]       msg;
    logic [47:0]       client;
    logic [7:0]        frag;
    logic [7:0]        total;
    logic [15:0]       mfd;
    logic              has_data;
    logic [15:0]       plen;
    logic [NB_W-1:0]   nb;
    logic [POS_W-1:0]  rawpos;
  } item_t;

  typedef struct packed {
    status_t      status;
    logic [2:0]   slot;
    logic         nack_valid;
    logic [7:0]   nack_frag;
    logic         data_valid;
    logic [4:0]   dest_block;
    logic [11:0]  dest_offset;
    logic [15:0]  data_len;
    logic         alloc_valid;
    logic [4:0]   alloc_blocks;
    logic [4:0]   block_count;
  } result_t;

endpackage

// ===== design/frt_front.sv =====
// Front end: takes requests, works out data length, block need and raw position.
module frt_front #(
  parameter int MAX_FRAGS  = frt_pkg::MAX_FRAGS_DEF,
  parameter int PAGE_BYTES = frt_pkg::PAGE_BYTES_DEF,
  parameter int MSG_BYTES  = frt_pkg::MSG_BYTES_DEF,
  parameter int MAX_BLOCKS = frt_pkg::MAX_BLOCKS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [159:0]   in_data,
  input  logic [2:0]     in_user,
  output logic           out_valid,
  input  logic           out_ready,
  output frt_pkg::item_t out_item
);

  localparam int POS_LIMIT = MAX_BLOCKS * PAGE_BYTES;

  logic           held;
  frt_pkg::item_t item;
  frt_pkg::item_t item_next;

  logic [7:0]  frag;
  logic [15:0] fsize, hsize, mfd, psize, dlen;
  logic [17:0] nb_sum;
  logic [17:0] nb_raw;
  logic [23:0] raw, raw_off;

  always_comb begin
    frag  = in_data[87:80];
    fsize = in_data[111:96];
    hsize = in_data[127:112];
    mfd   = in_data[143:128];
    psize = in_data[159:144];
    dlen  = (fsize > hsize) ? fsize - hsize : 16'd0;

    item_next.req_type = frt_pkg::req_t'(in_user[0]);
    item_next.kind     = frt_pkg::kind_t'(in_user[2:1]);
    item_next.msg      = in_data[31:0];
    item_next.client   = in_data[79:32];
    item_next.frag     = frag;
    item_next.total    = in_data[95:88];
    item_next.mfd      = mfd;
    item_next.has_data = (frag != 8'd0) || (32'(dlen) > 32'(MSG_BYTES));
    item_next.plen     = (frag == 8'd0) ? 16'(dlen - 16'(MSG_BYTES)) : dlen;

    nb_sum = 18'(psize) + 18'(PAGE_BYTES - 1);
    nb_raw = 18'(nb_sum / PAGE_BYTES);
    if (32'(psize) <= 32'(PAGE_BYTES)) begin
      item_next.nb = frt_pkg::NB_W'(1);
    end else if (32'(nb_raw) > 32'(MAX_BLOCKS)) begin
      item_next.nb = frt_pkg::NB_W'(MAX_BLOCKS);
    end else begin
      item_next.nb = frt_pkg::NB_W'(nb_raw);
    end

    raw     = 24'(frag) * 24'(mfd);
    raw_off = raw - 24'(MSG_BYTES);
    if (32'(raw) < 32'(MSG_BYTES)) begin
      item_next.rawpos = '0;
    end else if (32'(raw_off) > 32'(POS_LIMIT)) begin
      item_next.rawpos = frt_pkg::POS_W'(POS_LIMIT);
    end else begin
      item_next.rawpos = frt_pkg::POS_W'(raw_off);
    end
  end

  assign in_ready  = !held || out_ready;
  assign out_valid = held;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (out_ready) begin
      held <= 1'b0;
    end
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

// ===== design/frt_queue.sv =====
// Two-entry request queue between front and back.
module frt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  frt_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output frt_pkg::item_t rd_item
);

  frt_pkg::item_t mem [2];
  logic           wp, rp;
  logic [1:0]     count;
  logic           push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = mem[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      mem[wp] <= wr_item;
    end
  end

endmodule

// ===== design/frt_back.sv =====
// Back end: slot table, lookup and update, catch-up scan, result register.
module frt_back #(
  parameter int SLOTS      = frt_pkg::SLOTS_DEF,
  parameter int MAX_FRAGS  = frt_pkg::MAX_FRAGS_DEF,
  parameter int PAGE_BYTES = frt_pkg::PAGE_BYTES_DEF,
  parameter int MAX_BLOCKS = frt_pkg::MAX_BLOCKS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  frt_pkg::item_t   in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output frt_pkg::result_t out_res
);

  localparam int IW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW        = $clog2(MAX_FRAGS);
  localparam int JW        = $clog2(MAX_FRAGS + 1);
  localparam int PW        = frt_pkg::POS_W;
  localparam int POS_LIMIT = MAX_BLOCKS * PAGE_BYTES;
  localparam int NB_W_L    = frt_pkg::NB_W;

  frt_pkg::state_t  st, st_next;
  frt_pkg::item_t   cur;
  frt_pkg::result_t res, pend, look_res;
  logic [IW-1:0]    sidx;
  logic [JW-1:0]    j;

  logic                 vld     [SLOTS];
  logic [31:0]          smsg    [SLOTS];
  logic [47:0]          sclient [SLOTS];
  logic [7:0]           sexp    [SLOTS];
  logic [7:0]           srcv    [SLOTS];
  logic                 shb     [SLOTS];
  logic [NB_W_L-1:0]    sblk    [SLOTS];
  logic [PW-1:0]        spos    [SLOTS];
  logic [MAX_FRAGS-1:0] sbm     [SLOTS];

  logic                 hit, free;
  logic [IW-1:0]        hit_idx, free_idx, sel;
  logic [MAX_FRAGS-1:0] bm_o, bm1;
  logic [7:0]           exp_o, rcv_o, exp1, rcv1, exp_w;
  logic                 hb_o, hb1;
  logic [NB_W_L-1:0]    blk_o, blk1;
  logic [PW-1:0]        pos_o, pos_sel, pos1, pos_w;
  logic [23:0]          sum1;
  logic [FW-1:0]        fi, fim1;
  logic                 frag_bad, is_exp, do_scan, nack, dup;
  logic                 act_release, act_upd;

  logic          scan_in, scan_bit;
  logic [FW-1:0] jl;
  logic [23:0]   sum2;
  logic [PW-1:0] pos2;
  logic [7:0]    exp2;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (vld[i] && smsg[i] == cur.msg && sclient[i] == cur.client && !hit) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
      if (!vld[i]) begin
        free     = 1'b1;
        free_idx = IW'(i);
      end
    end
    sel   = hit ? hit_idx : free_idx;
    bm_o  = hit ? sbm[sel] : '0;
    exp_o = hit ? sexp[sel] : 8'd0;
    rcv_o = hit ? srcv[sel] : 8'd0;
    hb_o  = hit ? shb[sel] : 1'b0;
    blk_o = hit ? sblk[sel] : '0;
    pos_o = hit ? spos[sel] : '0;

    fi       = cur.frag[FW-1:0];
    fim1     = (cur.frag != 8'd0) ? fi - 1'b1 : '0;
    frag_bad = {1'b0, cur.frag} >= 9'(MAX_FRAGS);
    dup      = bm_o[fi];
    is_exp   = cur.frag == exp_o;
    pos_sel  = is_exp ? pos_o : cur.rawpos;
    sum1     = 24'(pos_sel) + 24'(cur.plen);
    pos1     = (32'(sum1) > 32'(POS_LIMIT)) ? PW'(POS_LIMIT) : PW'(sum1);
    exp1     = (exp_o == 8'd255) ? exp_o : exp_o + 8'd1;
    rcv1     = (rcv_o == 8'd255) ? rcv_o : rcv_o + 8'd1;
    do_scan  = cur.has_data && is_exp && cur.kind == frt_pkg::KIND_RETX &&
               (({1'b0, cur.frag} + 9'd1) != ({1'b0, cur.total} - 9'd1));
    nack     = cur.has_data && !is_exp && cur.kind == frt_pkg::KIND_NORMAL &&
               cur.frag != 8'd0 && !bm_o[fim1];
    bm1      = bm_o;
    if (cur.has_data) bm1[fi] = 1'b1;
    hb1      = hb_o || cur.has_data;
    blk1     = (cur.has_data && !hb_o) ? cur.nb : blk_o;
    exp_w    = (cur.has_data && is_exp) ? exp1 : exp_o;
    pos_w    = (cur.has_data && is_exp) ? pos1 : pos_o;

    act_release = 1'b0;
    act_upd     = 1'b0;
    look_res    = '0;
    if (cur.req_type == frt_pkg::REQ_RELEASE) begin
      if (hit) begin
        act_release     = 1'b1;
        look_res.status = frt_pkg::ST_RELEASED;
        look_res.slot   = 3'(hit_idx);
      end else begin
        look_res.status = frt_pkg::ST_NOTFOUND;
      end
    end else if (cur.kind == frt_pkg::KIND_OTHER || cur.kind == frt_pkg::KIND_RSVD) begin
      look_res.status = frt_pkg::ST_IGNORED;
    end else if (frag_bad) begin
      look_res.status = frt_pkg::ST_RANGE;
    end else if (!hit && !free) begin
      look_res.status = frt_pkg::ST_FULL;
    end else if (dup) begin
      look_res.status = frt_pkg::ST_DUP;
      look_res.slot   = 3'(sel);
    end else begin
      act_upd       = 1'b1;
      look_res.slot = 3'(sel);
      if (cur.has_data) begin
        look_res.alloc_valid  = !hb_o;
        look_res.alloc_blocks = hb_o ? 5'd0 : 5'(cur.nb);
        look_res.data_valid   = 1'b1;
        look_res.dest_block   = 5'(pos_sel / PAGE_BYTES);
        look_res.dest_offset  = 12'(pos_sel % PAGE_BYTES);
        look_res.data_len     = cur.plen;
        look_res.nack_valid   = nack;
        look_res.nack_frag    = nack ? exp_o : 8'd0;
      end
      if (rcv1 >= cur.total) begin
        look_res.status      = frt_pkg::ST_COMPLETE;
        look_res.block_count = hb1 ? 5'(blk1) : 5'd0;
      end else begin
        look_res.status = frt_pkg::ST_STORED;
      end
    end
  end

  always_comb begin
    scan_in  = 32'(j) < 32'(MAX_FRAGS);
    jl       = j[FW-1:0];
    scan_bit = scan_in ? sbm[sidx][jl] : 1'b0;
    sum2     = 24'(spos[sidx]) + 24'(cur.mfd);
    pos2     = (32'(sum2) > 32'(POS_LIMIT)) ? PW'(POS_LIMIT) : PW'(sum2);
    exp2     = (sexp[sidx] == 8'd255) ? sexp[sidx] : sexp[sidx] + 8'd1;
  end

  always_comb begin
    st_next = st;
    case (st)
      frt_pkg::S_IDLE: if (in_valid) st_next = frt_pkg::S_LOOK;
      frt_pkg::S_LOOK: st_next = (act_upd && do_scan) ? frt_pkg::S_SCAN : frt_pkg::S_DONE;
      frt_pkg::S_SCAN: if (!scan_bit) st_next = frt_pkg::S_DONE;
      frt_pkg::S_DONE: if (!out_valid || out_ready) st_next = frt_pkg::S_IDLE;
      default:         st_next = frt_pkg::S_IDLE;
    endcase
  end

  assign in_ready = (st == frt_pkg::S_IDLE);
  assign out_res  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= frt_pkg::S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) vld[i] <= 1'b0;
    end else begin
      st <= st_next;
      if (st == frt_pkg::S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (st == frt_pkg::S_LOOK) begin
        if (act_release) vld[hit_idx] <= 1'b0;
        if (act_upd) vld[sel] <= 1'b1;
      end
    end

    if (st == frt_pkg::S_IDLE && in_valid) cur <= in_item;
    // the result register only moves when the previous result is gone
    if (st == frt_pkg::S_DONE && (!out_valid || out_ready)) begin
      res <= pend;
    end
    if (st == frt_pkg::S_LOOK) begin
      pend <= look_res;
      sidx <= sel;
      j    <= JW'(cur.frag) + JW'(1);
      if (act_upd) begin
        smsg[sel]    <= cur.msg;
        sclient[sel] <= cur.client;
        sbm[sel]     <= bm1;
        sexp[sel]    <= exp_w;
        srcv[sel]    <= rcv1;
        shb[sel]     <= hb1;
        sblk[sel]    <= blk1;
        spos[sel]    <= pos_w;
      end
    end
    if (st == frt_pkg::S_SCAN && scan_bit) begin
      sexp[sidx] <= exp2;
      spos[sidx] <= pos2;
      j          <= j + JW'(1);
    end
  end

endmodule

// ===== design/fragment_reassembly_tracker.sv =====
// Fragment reassembly tracker: top level with stream ports.
//
// Requests come in on s_axis (fragment arrivals and slot releases); one
// result per request leaves on m_axis, in request order. The slave side
// registers each request and works out its data length, block count and
// raw page position; a two-entry queue feeds the slot table sequencer.
// In the sequencer a request passes through dispatch, table lookup and
// update, and result load; after a retransmission of the expected fragment
// a catch-up scan runs between lookup and result load, skipping each held
// fragment and ending at the first one not held or at MAX_FRAGS. The table
// lookup compares all slots at once; the scan walks the fragment bitmap
// one bit a cycle. The front keeps accepting requests into the queue
// while the sequencer works or a result waits.
// Reset frees every slot and empties the front, queue and result
// register. When m_axis_tready is low the result holds, the sequencer
// stops at its result stage, and the queue then fills and drops
// s_axis_tready.
module fragment_reassembly_tracker #(
  parameter int SLOTS      = frt_pkg::SLOTS_DEF,
  parameter int MAX_FRAGS  = frt_pkg::MAX_FRAGS_DEF,
  parameter int PAGE_BYTES = frt_pkg::PAGE_BYTES_DEF,
  parameter int MSG_BYTES  = frt_pkg::MSG_BYTES_DEF,
  parameter int MAX_BLOCKS = frt_pkg::MAX_BLOCKS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // msg_num, client_key, frag_num, total_frags, frag_size, head_size,
  // max_frag_data, page byte count
  input  logic [159:0] s_axis_tdata,
  // req_type, pkt_kind
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // slot, nack_valid, nack_frag, data_valid, dest_block, dest_offset,
  // data_len, alloc_valid, alloc_blocks, block_count, zero pad
  output logic [63:0]  m_axis_tdata,
  // status
  output logic [2:0]   m_axis_tuser
);

  logic             f_valid, f_ready, q_valid, q_ready;
  frt_pkg::item_t   f_item, q_item;
  frt_pkg::result_t res;

  frt_front #(
    .MAX_FRAGS(MAX_FRAGS), .PAGE_BYTES(PAGE_BYTES),
    .MSG_BYTES(MSG_BYTES), .MAX_BLOCKS(MAX_BLOCKS)
  ) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata), .in_user(s_axis_tuser),
    .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
  );

  frt_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  frt_back #(
    .SLOTS(SLOTS), .MAX_FRAGS(MAX_FRAGS),
    .PAGE_BYTES(PAGE_BYTES), .MAX_BLOCKS(MAX_BLOCKS)
  ) u_back (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {7'd0, res.block_count, res.alloc_blocks, res.alloc_valid,
                         res.data_len, res.dest_offset, res.dest_block,
                         res.data_valid, res.nack_frag, res.nack_valid, res.slot};

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_full_slot0: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == frt_pkg::ST_FULL |-> m_axis_tdata[2:0] == 3'd0)
    else $error("table full result names a slot");

  a_nack_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[3] |->
      (m_axis_tuser == frt_pkg::ST_STORED || m_axis_tuser == frt_pkg::ST_COMPLETE))
    else $error("nack on a request that stored nothing");

  a_release_nodata: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == frt_pkg::ST_RELEASED |-> !m_axis_tdata[12])
    else $error("release result carries page data");

endmodule
